@@ design/mah_pkg.sv @@
// Shared constants and types for the moving-average hysteresis switch.
package mah_pkg;

  localparam int unsigned WINDOW   = 10;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned QSTEP_W  = $clog2(SUM_W);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_ON_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THR = CFG_IDX_W'(1);

  localparam logic [SAMPLE_W-1:0] ON_THR_RST  = SAMPLE_W'(2500);
  localparam logic [SAMPLE_W-1:0] OFF_THR_RST = SAMPLE_W'(2000);

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Running sum and fill count after the latest sample.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } ring_status_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

@@ design/moving_average_hysteresis_switch.sv @@
// Top level: moving-average filter with a hysteresis switch on the average.
//
// Samples enter on the s_axis channel, one 12-bit reading per beat in
// s_axis_tdata[11:0]. Each accepted beat yields exactly one result beat on the
// m_axis channel: the truncated mean of the samples in the window, the switch
// level after this sample and a flag that marks a change of level.
// The user must write the two thresholds through the cfg port only while the
// block is idle; the block itself does not enforce this.
// One sample occupies the block from acceptance to a valid result. The window
// is updated at the accepting edge. Then the divider is loaded, and it produces
// one quotient bit per cycle. The quotient is then handed over, and a last step
// loads the output register. s_axis_tready is low during that time and rises in
// the cycle after the load, so the block takes no new sample until the result
// of the last one is loaded.
// The result sits in an output register; a new sample is taken while it
// waits. If the receiver stalls, the next finished result waits in the
// divider until the output register is free, and no sample is taken then.
//
// Reset clears the window, the running sum, the fill count and the switch
// level (off) and restores the default thresholds.
module moving_average_hysteresis_switch (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mah_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [11:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] average, [12] switch_on, [13] switch_changed
  output logic [mah_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [mah_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mah_pkg::CFG_W-1:0]           cfg_data_i
);
  import mah_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]          state_q;
  logic [1:0]          state_d;
  logic [SAMPLE_W-1:0] on_thr_q;
  logic [SAMPLE_W-1:0] off_thr_q;
  logic                level_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_on_q;
  logic                out_chg_q;

  logic                in_fire;
  logic                out_free;
  logic                load_out;
  logic                level_d;
  logic                changed;
  logic [SAMPLE_W-1:0] avg;
  ring_status_t        ring_status;
  div_ctrl_t           div_in;
  div_ctrl_t           div_out;
  logic [SUM_W-1:0]    quotient;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load_out      = (state_q == ST_HOLD) && out_free;

  mah_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_fire),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .status_o (ring_status)
  );

  assign div_in.start = (state_q == ST_START);
  assign div_in.done  = 1'b0;

  mah_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_in),
    .ctrl_o     (div_out),
    .dividend_i (ring_status.sum),
    .divisor_i  (ring_status.count),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_out.done) state_d = ST_HOLD;
      ST_HOLD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Only the rule for the present level is tested, so one sample toggles at most once.
  always_comb begin
    avg     = quotient[SAMPLE_W-1:0];
    level_d = level_q;
    changed = 1'b0;
    if (!level_q) begin
      if (avg > on_thr_q) begin
        level_d = 1'b1;
        changed = 1'b1;
      end
    end else begin
      if (avg < off_thr_q) begin
        level_d = 1'b0;
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
      on_thr_q    <= ON_THR_RST;
      off_thr_q   <= OFF_THR_RST;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        level_q     <= level_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ON_THR:  on_thr_q  <= cfg_data_i[SAMPLE_W-1:0];
          REG_OFF_THR: off_thr_q <= cfg_data_i[SAMPLE_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q <= avg;
      out_on_q  <= level_d;
      out_chg_q <= changed;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SAMPLE_W - 2){1'b0}}, out_chg_q, out_on_q, out_avg_q};

endmodule

@@ design/mah_ring.sv @@
// Sample window: ring of the last samples, running sum and fill count.
module mah_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mah_pkg::SAMPLE_W-1:0]  sample_i,
  output mah_pkg::ring_status_t         status_o
);
  import mah_pkg::*;

  logic [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   slot_d;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_d;
  logic [CNT_W-1:0]    fill_q;
  logic [CNT_W-1:0]    fill_d;

  always_comb begin
    sum_d  = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(sample_i);
    slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
    fill_d = (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (wr_en_i) begin
      ring_q[slot_q] <= sample_i;
      slot_q         <= slot_d;
      sum_q          <= sum_d;
      fill_q         <= fill_d;
    end
  end

  assign status_o.sum   = sum_q;
  assign status_o.count = fill_q;

endmodule

@@ design/mah_div.sv @@
// Restoring divider: one quotient bit per cycle through a shared subtractor.
module mah_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mah_pkg::div_ctrl_t          ctrl_i,
  output mah_pkg::div_ctrl_t          ctrl_o,
  input  logic [mah_pkg::SUM_W-1:0]   dividend_i,
  input  logic [mah_pkg::CNT_W-1:0]   divisor_i,
  output logic [mah_pkg::SUM_W-1:0]   quotient_o
);
  import mah_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [QSTEP_W-1:0] step_q;
  logic [SUM_W-1:0]   quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [CNT_W-1:0]   dvs_q;
  logic [CNT_W:0]     trial;
  logic               ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + QSTEP_W'(1);
        if (step_q == QSTEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
    end
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;
  assign quotient_o   = quo_q;

endmodule

@@ design/mah_checker.sv @@
// Port-level checker for the moving-average hysteresis switch, with its bind.
module mah_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [mah_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mah_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             cfg_we_i,
  input logic [mah_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input logic [mah_pkg::CFG_W-1:0]        cfg_data_i
);
  import mah_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The block stays busy after taking a sample and does not take the next one at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("sample taken while the previous one is still in work");

  // A new result only appears straight after the block was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a sample in work");

  // The padding bits of the result beat stay zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:SAMPLE_W+2] == '0)
    else $error("result padding is not zero");

endmodule

bind moving_average_hysteresis_switch mah_checker u_mah_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the moving-average hysteresis switch.
module testbench;
  import mah_pkg::*;

  // Indexes past the two thresholds; writes to them must leave the block unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int unsigned IDLE_SETTLE = 4;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 20;

  typedef enum logic [1:0] {ACT_SAMPLE, ACT_CFG, ACT_DRAIN, ACT_HOLD_RX} act_kind_e;

  typedef struct {
    act_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [SAMPLE_W-1:0]   value;
    int unsigned           cycles;
  } plan_entry_t;

  typedef struct packed {
    logic                changed;
    logic                level;
    logic [SAMPLE_W-1:0] average;
  } switch_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [11:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [11:0] average, [12] switch_on, [13] switch_changed
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  moving_average_hysteresis_switch dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Shadow copy of the filter and switch state.
  logic [SAMPLE_W-1:0] shadow_ring [WINDOW];
  logic [SUM_W-1:0]    shadow_sum = '0;
  int unsigned         shadow_slot = 0;
  logic [CNT_W-1:0]    shadow_fill = '0;
  logic                shadow_level = 1'b0;
  logic [SAMPLE_W-1:0] shadow_on_thr = ON_THR_RST;
  logic [SAMPLE_W-1:0] shadow_off_thr = OFF_THR_RST;

  plan_entry_t    sample_plan [$];
  switch_result_t predicted_results [$];

  logic        sample_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  logic        rx_hold_token = 1'b0;
  int unsigned rx_hold_len = 0;

  int unsigned errors = 0;
  int unsigned n_samples = 0;
  int unsigned n_results = 0;
  int unsigned n_toggles = 0;
  int unsigned n_cfg = 0;

  function automatic switch_result_t filter_and_switch(input logic [SAMPLE_W-1:0] s);
    switch_result_t r;
    logic [SUM_W-1:0] q;
    shadow_sum = shadow_sum - SUM_W'(shadow_ring[shadow_slot]) + SUM_W'(s);
    shadow_ring[shadow_slot] = s;
    shadow_slot = (shadow_slot == WINDOW - 1) ? 0 : shadow_slot + 1;
    if (shadow_fill < CNT_W'(WINDOW)) shadow_fill = shadow_fill + 1'b1;
    q = shadow_sum / SUM_W'(shadow_fill);
    r.average = q[SAMPLE_W-1:0];
    r.changed = 1'b0;
    // Only the rule for the present level is tested, so crossed thresholds
    // cannot toggle twice in one beat.
    if (!shadow_level) begin
      if (r.average > shadow_on_thr) begin
        shadow_level = 1'b1;
        r.changed = 1'b1;
      end
    end else if (r.average < shadow_off_thr) begin
      shadow_level = 1'b0;
      r.changed = 1'b1;
    end
    r.level = shadow_level;
    return r;
  endfunction

  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_W'(v);
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit calm);
    plan_entry_t e;
    e.kind = ACT_SAMPLE;
    e.idx = '0;
    e.value = v;
    e.cycles = (calm || $urandom_range(0, 3) == 0) ? 0 : pick_idle_len();
    sample_plan.push_back(e);
  endtask

  task automatic push_drain();
    plan_entry_t e;
    e.kind = ACT_DRAIN;
    e.idx = '0;
    e.value = '0;
    e.cycles = 0;
    sample_plan.push_back(e);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] v);
    plan_entry_t e;
    push_drain();
    e.kind = ACT_CFG;
    e.idx = idx;
    e.value = v;
    e.cycles = 0;
    sample_plan.push_back(e);
  endtask

  task automatic push_rx_hold(input int unsigned len);
    plan_entry_t e;
    e.kind = ACT_HOLD_RX;
    e.idx = '0;
    e.value = '0;
    e.cycles = len;
    sample_plan.push_back(e);
  endtask

  // Input side: sends planned beats and register writes, waits on drains and passes hold requests on.
  always @(negedge clk_i) begin
    logic                  nv;
    logic [IN_TDATA_W-1:0] nd;
    logic                  nwe;
    logic [CFG_IDX_W-1:0]  nidx;
    logic [CFG_W-1:0]      nval;
    logic                  idle;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    nwe = 1'b0;
    nidx = cfg_idx_i;
    nval = cfg_data_i;
    idle = (predicted_results.size() == 0) && (quiet_cycles >= IDLE_SETTLE);
    if (rst_ni) begin
      if (s_axis_tvalid && sample_taken) nv = 1'b0;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_plan.size() > 0) begin
          case (sample_plan[0].kind)
            ACT_SAMPLE: begin
              nv = 1'b1;
              nd = IN_TDATA_W'(sample_plan[0].value);
              gap_left = sample_plan[0].cycles;
              void'(sample_plan.pop_front());
            end
            ACT_CFG: begin
              if (idle) begin
                nwe = 1'b1;
                nidx = sample_plan[0].idx;
                nval = sample_plan[0].value;
                void'(sample_plan.pop_front());
              end
            end
            ACT_DRAIN: begin
              if (idle) void'(sample_plan.pop_front());
            end
            default: begin
              rx_hold_len <= sample_plan[0].cycles;
              rx_hold_token <= !rx_hold_token;
              void'(sample_plan.pop_front());
            end
          endcase
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
    cfg_we_i <= nwe;
    cfg_idx_i <= nidx;
    cfg_data_i <= nval;
  end

  // Output side: random stalls, calm stretches and the long hold on request.
  logic        rx_hold_seen = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_calm_left = 0;

  always @(negedge clk_i) begin
    int unsigned r;
    if (rst_ni) begin
      if (rx_hold_token != rx_hold_seen) begin
        rx_hold_seen = rx_hold_token;
        rx_wait = rx_hold_len;
      end
      r = $urandom_range(0, 99);
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else if (rx_calm_left > 0) begin
        rx_calm_left--;
        m_axis_tready <= 1'b1;
      end else if (r == 0) begin
        rx_calm_left = 300;
        m_axis_tready <= 1'b1;
      end else if (r < 30) begin
        rx_wait = pick_idle_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Accepted beats feed the shadow model; result beats are checked in order.
  always @(posedge clk_i) begin
    switch_result_t got;
    switch_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        n_cfg++;
        case (cfg_idx_i)
          REG_ON_THR:  shadow_on_thr = cfg_data_i[SAMPLE_W-1:0];
          REG_OFF_THR: shadow_off_thr = cfg_data_i[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = switch_result_t'(m_axis_tdata[$bits(switch_result_t)-1:0]);
        n_results++;
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result beat, average %0d level %0b changed %0b",
                     $time, got.average, got.level, got.changed);
        end else begin
          want = predicted_results.pop_front();
          if (got.changed) n_toggles++;
          if (got.average !== want.average) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: average mismatch, expected %0d, actual %0d",
                       $time, want.average, got.average);
          end
          if (got.level !== want.level) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: switch_on mismatch, expected %0b, actual %0b",
                       $time, want.level, got.level);
          end
          if (got.changed !== want.changed) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: switch_changed mismatch, expected %0b, actual %0b",
                       $time, want.changed, got.changed);
          end
        end
      end
      sample_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.push_back(filter_and_switch(s_axis_tdata[SAMPLE_W-1:0]));
        n_samples++;
      end
      if (predicted_results.size() == 0 && !s_axis_tvalid)
        quiet_cycles <= (quiet_cycles < 1000) ? quiet_cycles + 1 : quiet_cycles;
      else
        quiet_cycles <= 0;
    end
  end

  initial begin
    int ph;
    int cnt;
    int len;
    int on_v;
    int off_v;
    int thr;
    int v;
    bit calm;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;

    // Directed part, default thresholds first: full scale turns the switch on,
    // then zeros pull the average down through both thresholds.
    push_sample(12'hFFF, 1'b0);
    push_sample(12'h000, 1'b0);
    push_sample(12'h000, 1'b0);
    push_sample(12'hAAA, 1'b0);
    push_sample(12'h555, 1'b0);
    push_cfg(REG_SPARE_A, 12'hFFF);
    push_cfg(REG_SPARE_B, 12'h000);
    // The average can never be strictly above 4095 nor below 0: the level freezes.
    push_cfg(REG_ON_THR, 12'hFFF);
    push_cfg(REG_OFF_THR, 12'h000);
    repeat (10) push_sample(12'hFFF, 1'b0);
    // Crossed thresholds: the level flips on every beat.
    push_cfg(REG_ON_THR, 12'h000);
    push_cfg(REG_OFF_THR, 12'hFFF);
    repeat (4) push_sample(SAMPLE_W'($urandom_range(1, 4094)), 1'b0);
    push_sample(12'h000, 1'b0);

    for (ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          on_v = $urandom_range(1000, 3500);
          off_v = on_v - $urandom_range(0, 800);
        end
        1: begin
          on_v = $urandom_range(0, 1) ? 4095 : 0;
          off_v = $urandom_range(0, 1) ? 4095 : 0;
        end
        2: begin
          on_v = $urandom_range(200, 2000);
          off_v = on_v + $urandom_range(1, 1500);
        end
        default: begin
          on_v = $urandom_range(0, 4095);
          off_v = $urandom_range(0, 4095);
        end
      endcase
      push_cfg(REG_ON_THR, clamp_sample(on_v));
      push_cfg(REG_OFF_THR, clamp_sample(off_v));
      if (ph == 6) push_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                            SAMPLE_W'($urandom));
      calm = (ph % 3 == 1);
      // A long hold on the result side while beats keep coming fills the block.
      if (ph == 4) push_rx_hold(400);
      cnt = 0;
      while (cnt < 119) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Level run, mostly near a threshold, so the average often lands on or next to it.
            thr = $urandom_range(0, 1) ? on_v : off_v;
            v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                           : thr + $urandom_range(0, 4) - 2;
            len = $urandom_range(10, 14);
            repeat (len) push_sample(clamp_sample(v), calm);
          end
          4, 5: begin
            len = $urandom_range(5, 20);
            v = $urandom_range(0, 4095);
            thr = $urandom_range(0, 400) - 200;
            repeat (len) begin
              push_sample(clamp_sample(v), calm);
              v = v + thr;
            end
          end
          6, 7: begin
            len = $urandom_range(1, 8);
            repeat (len) push_sample(SAMPLE_W'($urandom), calm);
          end
          8: begin
            len = $urandom_range(1, 6);
            repeat (len) push_sample($urandom_range(0, 1) ? 12'hFFF : 12'h000, calm);
          end
          default: begin
            len = WINDOW;
            v = $urandom_range(0, 1) ? 4095 : 0;
            repeat (len) push_sample(SAMPLE_W'(v), calm);
          end
        endcase
        cnt = cnt + len;
      end
      // Sender waits for every result before the next phase.
      push_drain();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sample_plan.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    cnt = 0;
    while (predicted_results.size() != 0 && cnt < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      errors = errors + predicted_results.size();
      $display("%0t: %0d predicted results never arrived", $time, predicted_results.size());
    end

    $display("Run covered %0d samples and %0d result beats, %0d of them switch toggles.",
             n_samples, n_results, n_toggles);
    $display("Thresholds were written %0d times, including full-scale, crossed and spare indexes.",
             n_cfg);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
